FILE: design/ulc_pkg.sv
// ----------------------------------------------------------------------------
// ulc_pkg
// Types and constants shared by the UTC to local calendar pipeline.
// ----------------------------------------------------------------------------
package ulc_pkg;

   localparam int NUM_STAGES   = 8;
   localparam int FRONT_STAGES = 3;
   localparam int BACK_STAGES  = NUM_STAGES - FRONT_STAGES;

   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 11;
   localparam logic [CSR_INDEX_W-1:0] CSR_ZONE_OFFSET = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DAYLIGHT    = 1'd1;

   localparam int YEAR_BIAS     = 400;
   localparam int SECS_PER_DAY  = 86400;
   localparam int SECS_PER_HOUR = 3600;
   localparam int SECS_PER_MIN  = 60;
   localparam int DAYS_PER_ERA  = 146097;
   localparam int MAX_ERA       = 11;

   localparam int DIV100_SHIFT  = 19;
   localparam logic [12:0] DIV100_MUL  = 13'((2**DIV100_SHIFT + 99) / 100);
   localparam int DIV3600_SHIFT = 29;
   localparam logic [17:0] DIV3600_MUL = 18'((2**DIV3600_SHIFT + 3599) / 3600);
   localparam int DIV60_SHIFT   = 18;
   localparam logic [12:0] DIV60_MUL   = 13'((2**DIV60_SHIFT + 59) / 60);
   localparam int DIV1460_SHIFT = 28;
   localparam logic [17:0] DIV1460_MUL = 18'((2**DIV1460_SHIFT + 1459) / 1460);
   localparam int DIV365_SHIFT  = 26;
   localparam logic [17:0] DIV365_MUL  = 18'((2**DIV365_SHIFT + 364) / 365);

   // first day of each March-based month within the year
   localparam logic [8:0] MONTH_START [0:12] = '{
      9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153, 9'd184,
      9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd367
   };

   typedef struct packed {
      logic [11:0] utc_year;
      logic [3:0]  utc_month;
      logic [4:0]  utc_day;
      logic [4:0]  utc_hour;
      logic [5:0]  utc_minute;
      logic [5:0]  utc_second;
   } ulc_req_type;

   typedef struct packed {
      logic [11:0] local_year;
      logic [3:0]  local_month;
      logic [4:0]  local_day;
      logic [4:0]  local_hour;
      logic [5:0]  local_minute;
      logic [5:0]  local_second;
   } ulc_rsp_type;

   typedef struct packed {
      logic [20:0] day_num;
      logic [16:0] tod;
      logic [4:0]  hour;
   } ulc_mid_type;

endpackage

FILE: design/ulc_day_count.sv
// ----------------------------------------------------------------------------
// ulc_day_count
// Front three stages: UTC date to biased day number, local time of day.
// ----------------------------------------------------------------------------
module ulc_day_count (
   input  logic                                  clock,
   input  logic [ulc_pkg::FRONT_STAGES-1:0]      en,
   input  ulc_pkg::ulc_req_type                  req_payload,
   input  logic signed [ulc_pkg::CSR_DATA_W-1:0] zone_offset,
   input  logic                                  daylight,
   output ulc_pkg::ulc_mid_type                  mid
);

   logic               early;
   logic [3:0]         mpr;
   logic [12:0]        yp_in;
   logic signed [9:0]  doyd_in;
   logic [16:0]        pos_sec;
   logic signed [18:0] off_ext;
   logic signed [18:0] tsec_in;

   logic [12:0]        yp_ff;
   logic signed [9:0]  doyd_ff;
   logic signed [18:0] tsec_ff;

   logic signed [10:0] dk;
   logic signed [10:0] doyk;
   logic [20:0]        base_in;
   logic [25:0]        q100_prod;
   logic [23:0]        q400_prod;
   logic [6:0]         q100_in;
   logic [3:0]         q400_in;
   logic signed [18:0] tod_wide;
   logic [16:0]        tod_in;

   logic [20:0]        base_ff;
   logic [6:0]         q100_ff;
   logic [3:0]         q400_ff;
   logic [16:0]        tod_ff;

   logic [34:0]        hour_prod;
   ulc_pkg::ulc_mid_type mid_in;
   ulc_pkg::ulc_mid_type mid_ff;

   always_comb begin
      early   = (req_payload.utc_month <= 4'd2);
      mpr     = early ? (req_payload.utc_month + 4'd9) : (req_payload.utc_month - 4'd3);
      yp_in   = 13'(req_payload.utc_year) + 13'(ulc_pkg::YEAR_BIAS) - 13'(early);
      doyd_in = $signed({1'b0, ulc_pkg::MONTH_START[mpr]})
              + $signed({5'b0, req_payload.utc_day}) - 10'sd1;
      pos_sec = 17'(req_payload.utc_hour) * 17'(ulc_pkg::SECS_PER_HOUR)
              + 17'(req_payload.utc_minute) * 17'(ulc_pkg::SECS_PER_MIN)
              + 17'(req_payload.utc_second)
              + (daylight ? 17'(ulc_pkg::SECS_PER_HOUR) : 17'd0);
      off_ext = {{8{zone_offset[10]}}, zone_offset};
      tsec_in = $signed({2'b00, pos_sec}) + off_ext * 19'sd60;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         yp_ff   <= yp_in;
         doyd_ff <= doyd_in;
         tsec_ff <= tsec_in;
      end
   end

   always_comb begin
      if (tsec_ff < 19'sd0) begin
         dk       = -11'sd1;
         tod_wide = tsec_ff + 19'(ulc_pkg::SECS_PER_DAY);
      end else if (tsec_ff < 19'(ulc_pkg::SECS_PER_DAY)) begin
         dk       = 11'sd0;
         tod_wide = tsec_ff;
      end else if (tsec_ff < 19'(2 * ulc_pkg::SECS_PER_DAY)) begin
         dk       = 11'sd1;
         tod_wide = tsec_ff - 19'(ulc_pkg::SECS_PER_DAY);
      end else begin
         dk       = 11'sd2;
         tod_wide = tsec_ff - 19'(2 * ulc_pkg::SECS_PER_DAY);
      end
      tod_in    = tod_wide[16:0];
      doyk      = {doyd_ff[9], doyd_ff} + dk;
      base_in   = 21'(yp_ff) * 21'd365 + 21'(yp_ff >> 2) + {{10{doyk[10]}}, doyk};
      q100_prod = 26'(yp_ff) * 26'(ulc_pkg::DIV100_MUL);
      q400_prod = 24'(yp_ff >> 2) * 24'(ulc_pkg::DIV100_MUL);
      q100_in   = 7'(q100_prod >> ulc_pkg::DIV100_SHIFT);
      q400_in   = 4'(q400_prod >> ulc_pkg::DIV100_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         base_ff <= base_in;
         q100_ff <= q100_in;
         q400_ff <= q400_in;
         tod_ff  <= tod_in;
      end
   end

   always_comb begin
      hour_prod      = 35'(tod_ff) * 35'(ulc_pkg::DIV3600_MUL);
      mid_in.day_num = base_ff - 21'(q100_ff) + 21'(q400_ff);
      mid_in.tod     = tod_ff;
      mid_in.hour    = 5'(hour_prod >> ulc_pkg::DIV3600_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         mid_ff <= mid_in;
      end
   end

   assign mid = mid_ff;

endmodule

FILE: design/ulc_civil_date.sv
// ----------------------------------------------------------------------------
// ulc_civil_date
// Back five stages: biased day number to local date, time of day split.
// ----------------------------------------------------------------------------
module ulc_civil_date (
   input  logic                                clock,
   input  logic [ulc_pkg::BACK_STAGES-1:0]     en,
   input  ulc_pkg::ulc_mid_type                mid,
   output ulc_pkg::ulc_rsp_type                rsp_payload
);

   logic [3:0]  era_in;
   logic [17:0] doe_in;
   logic [11:0] rem_in;
   logic [3:0]  era3_ff;
   logic [17:0] doe3_ff;
   logic [4:0]  hour3_ff;
   logic [11:0] rem3_ff;

   logic [35:0] q1460_prod;
   logic [7:0]  q1460;
   logic [2:0]  q36524;
   logic [17:0] t_in;
   logic [24:0] min_prod;
   logic [5:0]  min_in;
   logic [17:0] t4_ff;
   logic [17:0] doe4_ff;
   logic [3:0]  era4_ff;
   logic [4:0]  hour4_ff;
   logic [5:0]  min4_ff;
   logic [11:0] rem4_ff;

   logic [35:0] yoe_prod;
   logic [8:0]  yoe_in;
   logic [5:0]  sec_in;
   logic [8:0]  yoe5_ff;
   logic [17:0] doe5_ff;
   logic [3:0]  era5_ff;
   logic [4:0]  hour5_ff;
   logic [5:0]  min5_ff;
   logic [5:0]  sec5_ff;

   logic [1:0]  c100;
   logic [8:0]  doy_in;
   logic [8:0]  doy6_ff;
   logic [8:0]  yoe6_ff;
   logic [3:0]  era6_ff;
   logic [4:0]  hour6_ff;
   logic [5:0]  min6_ff;
   logic [5:0]  sec6_ff;

   logic [3:0]  mp;
   ulc_pkg::ulc_rsp_type rsp_in;
   ulc_pkg::ulc_rsp_type rsp_ff;

   always_comb begin
      era_in = 4'd0;
      doe_in = 18'(mid.day_num);
      for (int j = 1; j <= ulc_pkg::MAX_ERA; j++) begin
         if (mid.day_num >= 21'(j * ulc_pkg::DAYS_PER_ERA)) begin
            era_in = 4'(j);
            doe_in = 18'(mid.day_num - 21'(j * ulc_pkg::DAYS_PER_ERA));
         end
      end
      rem_in = 12'(mid.tod - 17'(mid.hour) * 17'(ulc_pkg::SECS_PER_HOUR));
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         era3_ff  <= era_in;
         doe3_ff  <= doe_in;
         hour3_ff <= mid.hour;
         rem3_ff  <= rem_in;
      end
   end

   always_comb begin
      q1460_prod = 36'(doe3_ff) * 36'(ulc_pkg::DIV1460_MUL);
      q1460      = 8'(q1460_prod >> ulc_pkg::DIV1460_SHIFT);
      q36524     = 3'(doe3_ff >= 18'd36524) + 3'(doe3_ff >= 18'd73048)
                 + 3'(doe3_ff >= 18'd109572) + 3'(doe3_ff >= 18'd146096);
      t_in       = doe3_ff - 18'(q1460) + 18'(q36524) - 18'(doe3_ff == 18'd146096);
      min_prod   = 25'(rem3_ff) * 25'(ulc_pkg::DIV60_MUL);
      min_in     = 6'(min_prod >> ulc_pkg::DIV60_SHIFT);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         t4_ff    <= t_in;
         doe4_ff  <= doe3_ff;
         era4_ff  <= era3_ff;
         hour4_ff <= hour3_ff;
         min4_ff  <= min_in;
         rem4_ff  <= rem3_ff;
      end
   end

   always_comb begin
      yoe_prod = 36'(t4_ff) * 36'(ulc_pkg::DIV365_MUL);
      yoe_in   = 9'(yoe_prod >> ulc_pkg::DIV365_SHIFT);
      sec_in   = 6'(rem4_ff - 12'(min4_ff) * 12'(ulc_pkg::SECS_PER_MIN));
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         yoe5_ff  <= yoe_in;
         doe5_ff  <= doe4_ff;
         era5_ff  <= era4_ff;
         hour5_ff <= hour4_ff;
         min5_ff  <= min4_ff;
         sec5_ff  <= sec_in;
      end
   end

   always_comb begin
      c100   = 2'(yoe5_ff >= 9'd100) + 2'(yoe5_ff >= 9'd200) + 2'(yoe5_ff >= 9'd300);
      doy_in = 9'(doe5_ff - (18'(yoe5_ff) * 18'd365 + 18'(yoe5_ff >> 2) - 18'(c100)));
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         doy6_ff  <= doy_in;
         yoe6_ff  <= yoe5_ff;
         era6_ff  <= era5_ff;
         hour6_ff <= hour5_ff;
         min6_ff  <= min5_ff;
         sec6_ff  <= sec5_ff;
      end
   end

   always_comb begin
      mp = 4'd0;
      for (int j = 1; j <= 11; j++) begin
         if (doy6_ff >= ulc_pkg::MONTH_START[j]) begin
            mp = 4'(j);
         end
      end
      rsp_in.local_day    = 5'(doy6_ff - ulc_pkg::MONTH_START[mp] + 9'd1);
      rsp_in.local_month  = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
      rsp_in.local_year   = 12'(yoe6_ff) + 12'(13'(era6_ff) * 13'(ulc_pkg::YEAR_BIAS))
                          - 12'(ulc_pkg::YEAR_BIAS) + 12'(rsp_in.local_month <= 4'd2);
      rsp_in.local_hour   = hour6_ff;
      rsp_in.local_minute = min6_ff;
      rsp_in.local_second = sec6_ff;
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

FILE: design/utc_to_local_calendar_unit.sv
// ----------------------------------------------------------------------------
// utc_to_local_calendar_unit
// UTC date and time to local calendar date and time with zone and DST offset.
// ----------------------------------------------------------------------------
// Pipeline: the first of the 8 stages loads at acceptance, and rsp_valid rises
// once the transaction has moved on through every stage to the last one.
// Throughput: one transaction per cycle; each stage holds only when it is full
// and the stage after it cannot take its transaction.
// Reset: clears all stage valid bits, zone offset to 0 and daylight saving off.
// ----------------------------------------------------------------------------
module utc_to_local_calendar_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ulc_pkg::ulc_req_type                req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ulc_pkg::ulc_rsp_type                rsp_payload,
   input  logic                                csr_we,
   input  logic [ulc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ulc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   logic signed [ulc_pkg::CSR_DATA_W-1:0] zone_ff;
   logic                                  dst_ff;
   logic [ulc_pkg::NUM_STAGES-1:0]        vld_ff;
   logic [ulc_pkg::NUM_STAGES-1:0]        vld_in;
   logic [ulc_pkg::NUM_STAGES-1:0]        en;
   ulc_pkg::ulc_mid_type                  mid;

   always_ff @(posedge clock) begin
      if (reset) begin
         zone_ff <= '0;
         dst_ff  <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            ulc_pkg::CSR_ZONE_OFFSET: zone_ff <= $signed(csr_wdata);
            ulc_pkg::CSR_DAYLIGHT:    dst_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      en[ulc_pkg::NUM_STAGES-1] = !vld_ff[ulc_pkg::NUM_STAGES-1] || rsp_ready;
      for (int i = ulc_pkg::NUM_STAGES - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
      vld_in[0] = en[0] ? req_valid : vld_ff[0];
      for (int i = 1; i < ulc_pkg::NUM_STAGES; i++) begin
         vld_in[i] = en[i] ? vld_ff[i-1] : vld_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_ready = en[0];
   assign rsp_valid = vld_ff[ulc_pkg::NUM_STAGES-1];

   ulc_day_count u_day_count (
      .clock       (clock),
      .en          (en[ulc_pkg::FRONT_STAGES-1:0]),
      .req_payload (req_payload),
      .zone_offset (zone_ff),
      .daylight    (dst_ff),
      .mid         (mid)
   );

   ulc_civil_date u_civil_date (
      .clock       (clock),
      .en          (en[ulc_pkg::NUM_STAGES-1:ulc_pkg::FRONT_STAGES]),
      .mid         (mid),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTHESIS
   a_empty_out_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("pipeline stalls with no transaction at the output");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> vld_ff[0])
      else $error("accepted transaction lost at first stage");

   a_local_fields_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.local_month >= 4'd1 && rsp_payload.local_month <= 4'd12
                 && rsp_payload.local_day >= 5'd1 && rsp_payload.local_hour <= 5'd23
                 && rsp_payload.local_minute <= 6'd59 && rsp_payload.local_second <= 6'd59)
      else $error("local date or time out of range");
`endif

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the UTC to local calendar pipeline. A scoreboard converts each
// accepted UTC transaction to a local date and time under the current zone and
// daylight settings and checks every response in order, while the request side
// runs in bursts and the response side stalls on its own schedule.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT = 4000;
   localparam int LONG_HOLD  = 300;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PATTERN} rx_mode_type;

   class local_date_tracker;
      ulc_pkg::ulc_rsp_type expected_dates[$];
      int                   zone_minutes;
      bit                   dst_on;
      int                   errors;

      function void set_zone(logic [ulc_pkg::CSR_DATA_W-1:0] raw);
         zone_minutes = $signed(raw);
      endfunction

      function void set_daylight(logic [ulc_pkg::CSR_DATA_W-1:0] raw);
         dst_on = raw[0];
      endfunction

      function longint floor_quot(longint a, longint b);
         longint q;
         q = a / b;
         if ((a % b) != 0 && a < 0) q -= 1;
         return q;
      endfunction

      function ulc_pkg::ulc_rsp_type utc_to_local(ulc_pkg::ulc_req_type r);
         longint y, m, d, hh, mi, ss, secs, day, tod, z;
         longint era, yoe, doy, doe, mp, ly, lm, ld;
         ulc_pkg::ulc_rsp_type o;
         y  = r.utc_year;
         m  = r.utc_month;
         d  = r.utc_day;
         hh = r.utc_hour;
         mi = r.utc_minute;
         ss = r.utc_second;
         if (m <= 2) y -= 1;
         era  = floor_quot(y, 400);
         yoe  = y - era * 400;
         doy  = (153 * (m + ((m > 2) ? -3 : 9)) + 2) / 5 + d - 1;
         doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
         secs = (era * 146097 + doe - 719468) * 86400 + hh * 3600 + mi * 60 + ss;
         secs += longint'(zone_minutes) * 60 + (dst_on ? 3600 : 0);
         day  = floor_quot(secs, 86400);
         tod  = secs - day * 86400;
         z    = day + 719468;
         era  = floor_quot(z, 146097);
         doe  = z - era * 146097;
         yoe  = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
         doy  = doe - (365 * yoe + yoe / 4 - yoe / 100);
         mp   = (5 * doy + 2) / 153;
         ld   = doy - (153 * mp + 2) / 5 + 1;
         lm   = mp + ((mp < 10) ? 3 : -9);
         ly   = yoe + era * 400 + ((lm <= 2) ? 1 : 0);
         o.local_year   = 12'(ly);
         o.local_month  = 4'(lm);
         o.local_day    = 5'(ld);
         o.local_hour   = 5'(tod / 3600);
         o.local_minute = 6'((tod % 3600) / 60);
         o.local_second = 6'(tod % 60);
         return o;
      endfunction

      function string stamp(ulc_pkg::ulc_rsp_type v);
         return $sformatf("%0d-%0d-%0d %0d:%0d:%0d", v.local_year, v.local_month,
                          v.local_day, v.local_hour, v.local_minute, v.local_second);
      endfunction

      function void note_request(ulc_pkg::ulc_req_type r);
         expected_dates.push_back(utc_to_local(r));
      endfunction

      function void check_response(ulc_pkg::ulc_rsp_type got);
         ulc_pkg::ulc_rsp_type want;
         if (expected_dates.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %s", stamp(got));
            return;
         end
         want = expected_dates.pop_front();
         if (got.local_year !== want.local_year || got.local_month !== want.local_month ||
             got.local_day !== want.local_day || got.local_hour !== want.local_hour ||
             got.local_minute !== want.local_minute ||
             got.local_second !== want.local_second) begin
            errors++;
            if (errors <= 10)
               $display("mismatch: expected %s got %s", stamp(want), stamp(got));
         end
      endfunction
   endclass

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   ulc_pkg::ulc_req_type            req_payload = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   ulc_pkg::ulc_rsp_type            rsp_payload;
   logic                            csr_we      = 1'b0;
   logic [ulc_pkg::CSR_INDEX_W-1:0] csr_index   = '0;
   logic [ulc_pkg::CSR_DATA_W-1:0]  csr_wdata   = '0;

   local_date_tracker book;
   int                idle_cycles;
   int                holds_asked;
   int                holds_done;

   always #4 clock = ~clock;

   utc_to_local_calendar_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) book.check_response(rsp_payload);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   // response side stall schedule
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      int          cyc;
      mode      = RX_OPEN;
      mode_left = 0;
      hold_left = 0;
      cyc       = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (holds_done != holds_asked) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(16, 128);
         end
         mode_left--;
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (mode)
               RX_OPEN:    rsp_ready <= 1'b1;
               RX_LIGHT:   rsp_ready <= ($urandom_range(0, 3) != 0);
               RX_HEAVY:   rsp_ready <= ($urandom_range(0, 3) == 0);
               default:    rsp_ready <= 1'(8'b1011_0010 >> cyc[2:0]);
            endcase
         end
      end
   end

   function automatic int pick(int lo, int hi);
      int roll;
      roll = $urandom_range(0, 3);
      if (roll == 0) return lo;
      if (roll == 1) return hi;
      return $urandom_range(lo, hi);
   endfunction

   function automatic ulc_pkg::ulc_req_type random_item();
      ulc_pkg::ulc_req_type r;
      logic [63:0] raw;
      if ($urandom_range(0, 9) < 2) begin
         raw = {$urandom(), $urandom()};
         r   = raw[$bits(ulc_pkg::ulc_req_type)-1:0];
      end else begin
         r.utc_year   = 12'(pick(1970, 2099));
         r.utc_month  = 4'(pick(1, 12));
         r.utc_day    = 5'(pick(1, 31));
         r.utc_hour   = 5'(pick(0, 23));
         r.utc_minute = 6'(pick(0, 59));
         r.utc_second = 6'(pick(0, 59));
      end
      return r;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic drive_item(input ulc_pkg::ulc_req_type item);
      req_payload <= item;
      req_valid   <= 1'b1;
      do @(posedge clock); while (!req_ready);
      book.note_request(item);
      @(negedge clock);
   endtask

   task automatic send_date(input int y, m, d, hh, mi, ss);
      ulc_pkg::ulc_req_type r;
      r.utc_year   = 12'(y);
      r.utc_month  = 4'(m);
      r.utc_day    = 5'(d);
      r.utc_hour   = 5'(hh);
      r.utc_minute = 6'(mi);
      r.utc_second = 6'(ss);
      drive_item(r);
   endtask

   task automatic run_items(input int count, input bit back_to_back);
      int burst_left;
      burst_left = $urandom_range(1, 24);
      for (int i = 0; i < count; i++) begin
         drive_item(random_item());
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (!back_to_back && i < count - 1) begin
               req_valid <= 1'b0;
               repeat ($urandom_range(1, 10)) @(negedge clock);
            end
         end
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (book.expected_dates.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [ulc_pkg::CSR_INDEX_W-1:0] index,
                            input logic [ulc_pkg::CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      @(negedge clock);
      csr_we    <= 1'b0;
      if (index == ulc_pkg::CSR_ZONE_OFFSET) book.set_zone(data);
      else book.set_daylight(data);
      @(negedge clock);
   endtask

   task automatic configure(input int zone, input bit dst);
      wait_drained();
      repeat (ulc_pkg::NUM_STAGES) @(negedge clock);
      write_csr(ulc_pkg::CSR_ZONE_OFFSET, ulc_pkg::CSR_DATA_W'(zone));
      write_csr(ulc_pkg::CSR_DAYLIGHT, {10'($urandom()), dst});
   endtask

   initial begin
      book = new();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_date(1970, 1, 1, 0, 0, 0);
      send_date(2099, 12, 31, 23, 59, 59);
      send_date(2000, 2, 29, 12, 30, 45);
      send_date(2100, 2, 28, 23, 59, 59);
      send_date(1999, 12, 31, 23, 59, 59);
      send_date(0, 0, 0, 0, 0, 0);
      send_date(4095, 15, 31, 31, 63, 63);
      send_date(2024, 13, 0, 24, 60, 60);
      send_date(2024, 1, 0, 0, 0, 0);
      send_date(2023, 14, 31, 0, 0, 0);

      configure(-1024, 1'b0);
      send_date(1970, 1, 1, 0, 0, 0);
      send_date(1970, 1, 1, 17, 3, 59);
      send_date(2024, 3, 1, 0, 0, 0);
      send_date(0, 1, 1, 0, 0, 0);
      send_date(2000, 1, 1, 0, 0, 0);

      configure(1023, 1'b1);
      send_date(4095, 12, 31, 23, 0, 0);
      send_date(2099, 12, 31, 23, 59, 59);
      send_date(2024, 2, 28, 22, 0, 0);
      send_date(1970, 1, 1, 0, 0, 0);

      configure(-720, 1'b0);
      run_items(150, 1'b0);

      configure(840, 1'b1);
      holds_asked++;
      run_items(60, 1'b1);
      wait_drained();
      run_items(90, 1'b0);

      configure(0, 1'b1);
      run_items(150, 1'b0);

      for (int p = 0; p < 3; p++) begin
         configure(int'($signed(11'($urandom()))), 1'($urandom()));
         run_items(150, 1'b0);
      end

      wait_drained();
      repeat (ulc_pkg::NUM_STAGES + 4) @(posedge clock);
      book.errors += book.expected_dates.size();
      if (book.errors == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end

endmodule
